// File: rtl/tagged_region_extractor_unit_defines.svh
`ifndef TAGGED_REGION_EXTRACTOR_UNIT_DEFINES_SVH
`define TAGGED_REGION_EXTRACTOR_UNIT_DEFINES_SVH

// Check a property on every rising edge of clk_i, held off during reset.
`define TREU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition implies another one in the following cycle.
`define TREU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/treu_pkg.sv
`timescale 1ns / 1ps

package treu_pkg;

  // Bytes counted back from the top of the history where the name scan starts.
  localparam int NAME_GAP = 9;

  // Match phases: idle, partial opening match, inside a region, partial close.
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_OPEN_FIRST = 5'd1;
  localparam logic [4:0] PH_TAG_FULL   = 5'd9;
  localparam logic [4:0] PH_REGION     = 5'd16;
  localparam logic [4:0] PH_CLOSE_1    = 5'd17;
  localparam logic [4:0] PH_CLOSE_FULL = 5'd22;

  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_R     = 8'h72;

  // Header byte sequence: opening comment, then close of comment and tag.
  localparam logic [4:0] HDR_OPEN_LAST = 5'd4;
  localparam logic [4:0] HDR_LAST      = 5'd19;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_HEAD,
    ST_NAME_RD,
    ST_NAME_CHK,
    ST_TAIL,
    ST_CLOSE_NL
  } treu_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       flush;
    logic       rend;
  } treu_push_t;

  function automatic logic is_name_byte(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], 8'h2d, 8'h5f});
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [4:0] k);
    logic [7:0] b;
    case (k)
      5'd0:    b = 8'h3c;
      5'd1:    b = 8'h21;
      5'd2:    b = 8'h2d;
      5'd3:    b = 8'h2d;
      5'd4:    b = 8'h20;
      5'd5:    b = 8'h20;
      5'd6:    b = 8'h2d;
      5'd7:    b = 8'h2d;
      5'd8:    b = 8'h3e;
      5'd9:    b = 8'h0a;
      5'd10:   b = 8'h3c;
      5'd11:   b = 8'h6c;
      5'd12:   b = 8'h65;
      5'd13:   b = 8'h76;
      5'd14:   b = 8'h65;
      5'd15:   b = 8'h6c;
      5'd16:   b = 8'h20;
      5'd17:   b = 8'h76;
      5'd18:   b = 8'h65;
      5'd19:   b = 8'h72;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/treu_hist.sv
`timescale 1ns / 1ps

module treu_hist import treu_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [7:0]                 wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH+1)-1:0] rd_idx_i,
  output logic [7:0]                 rd_data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [AW-1:0]    wp_q, wp_d;
  logic [SW-1:0]    sum;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data_q;

  // wp_q addresses the oldest entry, which is logical index 0.
  always_comb begin
    wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
    sum  = SW'(wp_q) + SW'(rd_idx_i);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    rd_addr = sum[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      vld_q <= '0;
    end else if (wr_en_i) begin
      wp_q         <= wp_d;
      vld_q[wp_q]  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wp_q] <= wr_data_i;
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : 8'h00;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/treu_pack.sv
`timescale 1ns / 1ps

module treu_pack import treu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  treu_push_t push_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [31:0] out_bytes_o,
  output logic [2:0] out_count_o,
  output logic       region_end_o,
  output logic       last_o
);

  logic [23:0] acc_q;
  logic [1:0]  cnt_q;
  logic        ov_q;
  logic [31:0] word_q, word_d;
  logic [2:0]  count_q;
  logic        rend_q, last_q;
  logic        push_ok, emit;

  assign ready_o = !ov_q || out_ready_i;
  assign push_ok = push_valid_i && ready_o;
  assign emit    = push_ok && (push_i.flush || cnt_q == 2'd3);

  // Drop the new byte in at the next free lane; lanes above stay zero.
  assign word_d = {8'h00, acc_q} | ({24'h000000, push_i.data} << {cnt_q, 3'b000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (push_ok) begin
        if (emit) begin
          acc_q <= '0;
          cnt_q <= '0;
        end else begin
          acc_q <= word_d[23:0];
          cnt_q <= cnt_q + 2'd1;
        end
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q  <= word_d;
      count_q <= {1'b0, cnt_q} + 3'd1;
      rend_q  <= push_i.rend;
      last_q  <= push_i.flush;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_bytes_o  = word_q;
  assign out_count_o  = count_q;
  assign region_end_o = rend_q;
  assign last_o       = last_q;

endmodule

// File: rtl/tagged_region_extractor_unit.sv
// Byte inside a region: its result is in the output register in the cycle after it is accepted.
// Closing '>': the '>' and a newline leave together as one final result. Opening 'r': the
// sequencer scans the history down for the name, then emits the header, the name and the tail.
// Sustained throughput one byte per cycle while out_ready_i stays high and the sequencer runs.
// Reset (rst_ni low, asynchronous) clears the phase, sequencer and packer; the history
// reads as all zero bytes through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "tagged_region_extractor_unit_defines.svh"

module tagged_region_extractor_unit import treu_pkg::*; #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_bytes_o,
  output logic [2:0]  out_count_o,
  output logic        region_end_o,
  output logic        last_o
);

  localparam int IW        = $clog2(HISTORY_DEPTH + 1);
  localparam int START_RAW = HISTORY_DEPTH - NAME_GAP;
  // Scan start, held clear of index 0 and no higher than the top entry.
  localparam int START     = (START_RAW < 1) ? 1 :
                             ((START_RAW > HISTORY_DEPTH - 1) ? HISTORY_DEPTH - 1 : START_RAW);

  treu_state_e   state_q, state_d;
  logic [4:0]    phase_q, phase_d, np;
  logic [4:0]    k_q, k_d;
  logic [IW-1:0] idx_q, idx_d;

  logic          in_acc, inreg, hdr_start, closing, rd_name;
  logic          pack_ready, push_valid;
  treu_push_t    push;
  logic          hist_wr, hist_rd;
  logic [7:0]    hist_rd_data;

  assign in_acc  = in_valid_i && in_ready_o;
  assign rd_name = is_name_byte(hist_rd_data);

  // Next match phase for the byte on the input; partial-match phases count matched bytes.
  always_comb begin
    inreg = phase_q[4];
    np    = inreg ? PH_REGION : PH_IDLE;
    case (in_byte_i)
      CH_LT: begin
        // A '<' restarts the opening match rather than dropping it.
        np = inreg ? PH_REGION : PH_OPEN_FIRST;
      end
      CH_L: begin
        if (phase_q inside {5'd1, 5'd5, 5'd17, 5'd21}) np = phase_q + 5'd1;
      end
      CH_E: begin
        if (phase_q inside {5'd2, 5'd4, 5'd8, 5'd18, 5'd20}) np = phase_q + 5'd1;
      end
      CH_V: begin
        if (phase_q inside {5'd3, 5'd7, 5'd19}) np = phase_q + 5'd1;
      end
      CH_SLASH: begin
        if (phase_q == PH_REGION) np = PH_CLOSE_1;
      end
      CH_SPACE: begin
        if (phase_q == 5'd6) np = 5'd7;
      end
      CH_R: begin
        if (phase_q == PH_TAG_FULL) np = PH_REGION;
      end
      CH_GT: begin
        if (phase_q == PH_CLOSE_FULL) np = PH_IDLE;
      end
      default: begin
      end
    endcase
    hdr_start = (in_byte_i == CH_R) && (phase_q == PH_TAG_FULL);
    closing   = (in_byte_i == CH_GT) && (phase_q == PH_CLOSE_FULL);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_acc && hdr_start) begin
          state_d = ST_SCAN_RD;
        end else if (in_acc && closing) begin
          state_d = ST_CLOSE_NL;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        state_d = (idx_q != '0 && rd_name) ? ST_SCAN_RD : ST_HEAD;
      end
      ST_HEAD: begin
        if (pack_ready && k_q == HDR_OPEN_LAST) state_d = ST_NAME_RD;
      end
      ST_NAME_RD: begin
        state_d = (idx_q == IW'(HISTORY_DEPTH)) ? ST_TAIL : ST_NAME_CHK;
      end
      ST_NAME_CHK: begin
        if (!rd_name) begin
          state_d = ST_TAIL;
        end else if (pack_ready) begin
          state_d = ST_NAME_RD;
        end
      end
      ST_TAIL: begin
        if (pack_ready && k_q == HDR_LAST) state_d = ST_RUN;
      end
      ST_CLOSE_NL: begin
        if (pack_ready) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Sequencer outputs: input ready, packer requests and history port.
  always_comb begin
    in_ready_o = 1'b0;
    push_valid = 1'b0;
    push       = '{data: in_byte_i, flush: 1'b1, rend: 1'b0};
    hist_wr    = 1'b0;
    hist_rd    = 1'b0;
    case (state_q)
      ST_RUN: begin
        in_ready_o = pack_ready;
        if (in_acc) begin
          hist_wr = (np == PH_IDLE);
          if (closing) begin
            push_valid = 1'b1;
            push       = '{data: CH_GT, flush: 1'b0, rend: 1'b0};
          end else if (np[4] && !hdr_start) begin
            push_valid = 1'b1;
          end
        end
      end
      ST_SCAN_RD: hist_rd = 1'b1;
      ST_SCAN_CHK: begin
      end
      ST_HEAD: begin
        push_valid = 1'b1;
        push       = '{data: hdr_byte(k_q), flush: 1'b0, rend: 1'b0};
      end
      ST_NAME_RD: hist_rd = (idx_q != IW'(HISTORY_DEPTH));
      ST_NAME_CHK: begin
        push_valid = rd_name;
        push       = '{data: hist_rd_data, flush: 1'b0, rend: 1'b0};
      end
      ST_TAIL: begin
        // The tail closes with the opening 'r', which ends this request's results.
        push_valid = 1'b1;
        push       = '{data: hdr_byte(k_q), flush: (k_q == HDR_LAST), rend: 1'b0};
      end
      ST_CLOSE_NL: begin
        push_valid = 1'b1;
        push       = '{data: CH_NL, flush: 1'b1, rend: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Phase, header byte counter and history index.
  always_comb begin
    phase_d = in_acc ? np : phase_q;
    k_d     = k_q;
    idx_d   = idx_q;
    case (state_q)
      ST_RUN: begin
        k_d = '0;
        if (in_acc && hdr_start) idx_d = IW'(START);
      end
      ST_SCAN_CHK: begin
        // Step down over name bytes; on a stop, move to the first byte of the name.
        idx_d = (idx_q != '0 && rd_name) ? idx_q - IW'(1) : idx_q + IW'(1);
      end
      ST_HEAD, ST_TAIL: begin
        if (pack_ready) k_d = k_q + 5'd1;
      end
      ST_NAME_CHK: begin
        if (rd_name && pack_ready) idx_d = idx_q + IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      phase_q <= PH_IDLE;
      k_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      idx_q   <= idx_d;
    end
  end

  treu_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (hist_wr),
    .wr_data_i (in_byte_i),
    .rd_en_i   (hist_rd),
    .rd_idx_i  (idx_q),
    .rd_data_o (hist_rd_data)
  );

  treu_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push),
    .ready_o      (pack_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_bytes_o  (out_bytes_o),
    .out_count_o  (out_count_o),
    .region_end_o (region_end_o),
    .last_o       (last_o)
  );

  `TREU_ASSERT_NEXT(a_hdr_start, in_acc && hdr_start,
                    state_q == ST_SCAN_RD && phase_q == PH_REGION,
                    "header sequence did not start on opening match")
  `TREU_ASSERT(a_rend_shape,
               out_valid_o && region_end_o |->
                 last_o && out_count_o == 3'd2 && out_bytes_o[15:8] == CH_NL,
               "region end result is not a final closing pair")
  `TREU_ASSERT(a_count_range, out_valid_o |-> out_count_o != 3'd0 && out_count_o <= 3'd4,
               "result byte count out of range")
  `TREU_ASSERT(a_phase_legal, !phase_q[4] |-> phase_q <= PH_TAG_FULL,
               "idle-side phase beyond full opening match")
  `TREU_ASSERT(a_idx_range,
               (state_q == ST_NAME_RD || state_q == ST_NAME_CHK) |->
                 idx_q <= IW'(HISTORY_DEPTH) && idx_q != '0,
               "name index left the history")

endmodule
